/* hw/rtl/ats_pkg.sv */
// ----------------------------------------------------------------------------
// ats_pkg: shared types and constants of the assembler token scanner
// Token type codes, result and bundle layouts, character codes.
// ----------------------------------------------------------------------------
package ats_pkg;

   // token type codes as seen on the result channel
   typedef enum logic [3:0] {
      TT_ERROR     = 4'd0,
      TT_EOF       = 4'd1,
      TT_IDENT     = 4'd2,
      TT_INT       = 4'd3,
      TT_DIRECTIVE = 4'd4,
      TT_NEWLINE   = 4'd5,
      TT_LABEL     = 4'd6,
      TT_LIMIT     = 4'd7,
      TT_FORMAT    = 4'd8
   } tok_type;

   // result kinds
   localparam logic RK_CHAR = 1'b0;
   localparam logic RK_END  = 1'b1;

   // one result beat
   typedef struct packed {
      logic          kind;
      logic [7:0]    ch;
      tok_type       ttype;
      logic [31:0]   value;
      logic [19:0]   line;
      logic [7:0]    len;
   } result_type;

   // all results caused by one input beat, slot 0 first
   typedef struct packed {
      logic [1:0]          count;
      result_type [2:0]    slot;
   } bundle_type;

   // depth of the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // line counter
   localparam logic [19:0] LINE_RESET = 20'd1;
   localparam logic [19:0] LINE_MAX   = 20'hFFFFF;

   // character codes
   localparam logic [7:0] CH_TAB        = 8'h09;
   localparam logic [7:0] CH_NL         = 8'h0A;
   localparam logic [7:0] CH_CR         = 8'h0D;
   localparam logic [7:0] CH_SPACE      = 8'h20;
   localparam logic [7:0] CH_DOLLAR     = 8'h24;
   localparam logic [7:0] CH_LPAREN     = 8'h28;
   localparam logic [7:0] CH_RPAREN     = 8'h29;
   localparam logic [7:0] CH_DASH       = 8'h2D;
   localparam logic [7:0] CH_DOT        = 8'h2E;
   localparam logic [7:0] CH_ZERO       = 8'h30;
   localparam logic [7:0] CH_ONE        = 8'h31;
   localparam logic [7:0] CH_SEVEN      = 8'h37;
   localparam logic [7:0] CH_NINE       = 8'h39;
   localparam logic [7:0] CH_COLON      = 8'h3A;
   localparam logic [7:0] CH_SEMI       = 8'h3B;
   localparam logic [7:0] CH_LT         = 8'h3C;
   localparam logic [7:0] CH_GT         = 8'h3E;
   localparam logic [7:0] CH_A_UP       = 8'h41;
   localparam logic [7:0] CH_Z_UP       = 8'h5A;
   localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CH_A_LO       = 8'h61;
   localparam logic [7:0] CH_F_LO       = 8'h66;
   localparam logic [7:0] CH_X_LO       = 8'h78;
   localparam logic [7:0] CH_Z_LO       = 8'h7A;
   localparam logic [7:0] CH_LBRACE     = 8'h7B;
   localparam logic [7:0] CH_RBRACE     = 8'h7D;
   localparam logic [7:0] CASE_BIT      = 8'h20;

endpackage

/* hw/rtl/assembler_token_scanner.sv */
// ----------------------------------------------------------------------------
// assembler_token_scanner: character-at-a-time assembler lexer
// req_*: one source byte per beat (req_end_of_input closes the open token).
// rsp_*: echoed token characters and token-end records (type, length, line,
//   integer value), rsp_last set on the final result of each input beat.
// csr_*: write csr_wr_data to reload the line counter; write while idle.
// Path: each beat's bundle is registered in the queue, then in the output
//   register of the back end, from which its first result is sent.
// Throughput: one input beat per cycle while each beat makes at most one
//   result and rsp_stall is low; the output sends one result per cycle
//   unless stalled, sending each bundle from the back end's single register.
// A two-entry bundle queue sits between lexer and output; req_stall is high
//   only while that queue is full, so a stalled receiver holds its result and
//   backs up into the queue before the input stalls.
// Reset: lexer back in the start state, line counter 1, queue and output
//   empty.
// ----------------------------------------------------------------------------
module assembler_token_scanner #(
   parameter int TOKEN_CAPACITY = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [7:0]           req_in_char,
   input  logic                 req_end_of_input,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_result_kind,
   output logic [7:0]           rsp_token_char,
   output logic [3:0]           rsp_token_type,
   output logic signed [31:0]   rsp_int_value,
   output logic [19:0]          rsp_line_number,
   output logic [7:0]           rsp_token_length,
   output logic                 rsp_last,
   input  logic                 csr_wr_en,
   input  logic [19:0]          csr_wr_data
);
   import ats_pkg::*;

   logic          push;
   bundle_type    push_bundle;
   logic          q_full;
   logic          pop;
   logic          q_valid;
   bundle_type    q_head;

   // lexer front end
   ats_front #(
      .TOKEN_CAPACITY(TOKEN_CAPACITY)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_in_char      (req_in_char),
      .req_end_of_input (req_end_of_input),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .q_full           (q_full),
      .push             (push),
      .push_bundle      (push_bundle)
   );

   // bundle queue
   ats_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_bundle (push_bundle),
      .full        (q_full),
      .pop         (pop),
      .valid       (q_valid),
      .head        (q_head)
   );

   // result back end
   ats_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_head           (q_head),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_token_char   (rsp_token_char),
      .rsp_token_type   (rsp_token_type),
      .rsp_int_value    (rsp_int_value),
      .rsp_line_number  (rsp_line_number),
      .rsp_token_length (rsp_token_length),
      .rsp_last         (rsp_last)
   );

endmodule

/* hw/rtl/ats_front.sv */
// ----------------------------------------------------------------------------
// ats_front: lexer front end
// Takes one character beat per cycle unless stalled by a full queue, runs
// the lexer state machine and packs each beat's results into one queue bundle.
// ----------------------------------------------------------------------------
module ats_front #(
   parameter int TOKEN_CAPACITY = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [7:0]           req_in_char,
   input  logic                 req_end_of_input,
   input  logic                 csr_wr_en,
   input  logic [19:0]          csr_wr_data,
   input  logic                 q_full,
   output logic                 push,
   output ats_pkg::bundle_type  push_bundle
);
   import ats_pkg::*;

   localparam int KW = $clog2(TOKEN_CAPACITY);
   localparam logic [KW:0] KEPT_LIMIT = (KW+1)'(TOKEN_CAPACITY - 1);

   typedef enum logic [9:0] {
      ST_START   = 10'b0000000001,
      ST_COMMENT = 10'b0000000010,
      ST_IDENT   = 10'b0000000100,
      ST_LIM1    = 10'b0000001000,
      ST_LIM2    = 10'b0000010000,
      ST_DEC     = 10'b0000100000,
      ST_OCT     = 10'b0001000000,
      ST_HEX     = 10'b0010000000,
      ST_FMT     = 10'b0100000000,
      ST_SUB     = 10'b1000000000
   } scan_state_type;

   // token context carried from beat to beat
   typedef struct packed {
      scan_state_type    st;
      tok_type           pend;
      logic [KW-1:0]     kept;
      logic [31:0]       acc;
      logic              hexa;
   } ctx_type;

   // outcome of one character seen in the start state
   typedef struct packed {
      ctx_type       ctx;
      logic [1:0]    n;
      result_type    r0;
      result_type    r1;
      logic          tick;
   } step_type;

   localparam ctx_type CTX_CLEAR = '{st: ST_START, pend: TT_EOF, kept: '0,
                                     acc: '0, hexa: 1'b0};

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic is_lower(input logic [7:0] c);
      return (c >= CH_A_LO) && (c <= CH_Z_LO);
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

   function automatic result_type char_res(input logic [7:0] c);
      result_type r;
      r      = '0;
      r.kind = RK_CHAR;
      r.ch   = c;
      return r;
   endfunction

   function automatic result_type end_res(input tok_type t, input logic [31:0] acc,
                                          input logic [19:0] line,
                                          input logic [KW-1:0] k);
      result_type r;
      r       = '0;
      r.kind  = RK_END;
      r.ttype = t;
      r.value = (t == TT_INT) ? acc : 32'hFFFFFFFF;
      r.line  = line;
      r.len   = 8'(k);
      return r;
   endfunction

   // start state: '$' expands to "0x", line end and stray bytes close at once
   function automatic step_type start_feed(input logic [7:0] c, input ctx_type cin,
                                           input logic [19:0] line_now,
                                           input logic [19:0] line_inc);
      step_type      s;
      logic [KW-1:0] k1;
      k1     = cin.kept + KW'(1);
      s.ctx  = cin;
      s.n    = 2'd0;
      s.r0   = char_res(c);
      s.r1   = '0;
      s.tick = 1'b0;
      if (is_space(c) && (c != CH_NL)) begin
         s.n = 2'd0;
      end else if (is_lower(c)) begin
         s.ctx.pend = TT_IDENT;
         s.ctx.st   = ST_IDENT;
         s.ctx.kept = k1;
         s.n        = 2'd1;
      end else if (c == CH_ZERO) begin
         s.ctx.pend = TT_INT;
         s.ctx.st   = ST_OCT;
         s.ctx.acc  = '0;
         s.ctx.kept = k1;
         s.n        = 2'd1;
      end else if (is_digit(c)) begin
         s.ctx.pend = TT_INT;
         s.ctx.st   = ST_DEC;
         s.ctx.acc  = {28'd0, c[3:0]};
         s.ctx.kept = k1;
         s.n        = 2'd1;
      end else if (c == CH_DOT) begin
         s.ctx.pend = TT_DIRECTIVE;
         s.ctx.st   = ST_IDENT;
         s.ctx.kept = k1;
         s.n        = 2'd1;
      end else if (c == CH_SEMI) begin
         s.ctx.st   = ST_COMMENT;
         s.ctx.kept = k1;
         s.n        = 2'd1;
      end else if (c == CH_LBRACE) begin
         s.ctx.pend = TT_ERROR;
         s.ctx.st   = ST_FMT;
      end else if (c == CH_NL) begin
         s.n    = 2'd2;
         s.tick = 1'b1;
         s.r1   = end_res(TT_NEWLINE, cin.acc, line_inc, k1);
         s.ctx  = CTX_CLEAR;
      end else if (c == CH_DOLLAR) begin
         s.n        = 2'd2;
         s.r0       = char_res(CH_ZERO);
         s.r1       = char_res(CH_X_LO);
         s.ctx.st   = ST_HEX;
         s.ctx.pend = TT_INT;
         s.ctx.acc  = '0;
         s.ctx.hexa = (k1 == KW'(1));
         s.ctx.kept = k1 + KW'(1);
      end else begin
         s.n   = 2'd2;
         s.r1  = end_res(TT_ERROR, cin.acc, line_now, k1);
         s.ctx = CTX_CLEAR;
      end
      return s;
   endfunction

   ctx_type       ctx_ff, ctx_in;
   logic [19:0]   line_ff, line_in;

   logic [7:0]    ch;
   logic          accept;
   logic [19:0]   line_inc;
   ctx_type       a_ctx, back_ctx, nxt_ctx;
   logic          a_save, a_done, a_again, a_tick;
   logic [3:0]    hex_nib;
   logic          hex_ok;
   logic [KW:0]   kept_inc;
   result_type    a_end;
   step_type      s_start, s_again;
   logic [1:0]    nres;
   result_type    r0, r1, r2;
   logic          tick;

   // upper case folding
   assign ch = ((req_in_char >= CH_A_UP) && (req_in_char <= CH_Z_UP)) ?
               (req_in_char | CASE_BIT) : req_in_char;

   assign accept    = req_valid && !req_stall;
   assign req_stall = q_full;
   assign line_inc  = (line_ff == LINE_MAX) ? line_ff : line_ff + 20'd1;
   assign hex_ok    = is_digit(ch) || ((ch >= CH_A_LO) && (ch <= CH_F_LO));
   assign hex_nib   = is_digit(ch) ? ch[3:0] : ch[3:0] + 4'd9;

   // first pass of the character in the current state
   always_comb begin
      a_ctx   = ctx_ff;
      a_save  = 1'b1;
      a_done  = 1'b0;
      a_again = 1'b0;
      a_tick  = 1'b0;
      unique case (ctx_ff.st)
         ST_START: begin
            a_save = 1'b0;
         end
         ST_COMMENT: begin
            a_save = 1'b0;
            if ((ch == CH_NL) || (ch == CH_CR)) begin
               a_ctx.st   = ST_START;
               a_ctx.kept = '0;
               a_again    = 1'b1;
            end
         end
         ST_IDENT: begin
            if (ch == CH_COLON) begin
               a_ctx.pend = TT_LABEL;
               a_save     = 1'b0;
               a_done     = 1'b1;
            end else if (ch == CH_LT) begin
               a_ctx.pend = TT_ERROR;
               a_ctx.st   = ST_LIM1;
            end else if (!is_lower(ch) && !is_digit(ch) && (ch != CH_UNDERSCORE)) begin
               a_save  = 1'b0;
               a_again = 1'b1;
               a_done  = 1'b1;
            end
         end
         ST_LIM1: begin
            if (ch == CH_DASH) begin
               a_ctx.st = ST_LIM2;
            end else if (!is_digit(ch)) begin
               a_done = 1'b1;
            end
         end
         ST_LIM2: begin
            if (ch == CH_GT) begin
               a_ctx.pend = TT_LIMIT;
               a_done     = 1'b1;
            end else if (!is_digit(ch)) begin
               a_done = 1'b1;
            end
         end
         ST_DEC: begin
            if (is_digit(ch)) begin
               a_ctx.acc = {ctx_ff.acc[28:0], 3'b000} + {ctx_ff.acc[30:0], 1'b0}
                           + {28'd0, ch[3:0]};
            end else begin
               a_save  = 1'b0;
               a_again = 1'b1;
               a_done  = 1'b1;
            end
         end
         ST_OCT: begin
            if (ch == CH_X_LO) begin
               a_ctx.st   = ST_HEX;
               a_ctx.hexa = (ctx_ff.kept == KW'(1));
            end else if (is_digit(ch)) begin
               if (ch > CH_SEVEN) begin
                  a_ctx.pend = TT_ERROR;
               end
               a_ctx.acc = {ctx_ff.acc[28:0], 3'b000} + {28'd0, ch[3:0]};
            end else begin
               a_save  = 1'b0;
               a_again = 1'b1;
               a_done  = 1'b1;
            end
         end
         ST_HEX: begin
            if (!hex_ok) begin
               a_save  = 1'b0;
               a_again = 1'b1;
               a_done  = 1'b1;
            end else if (ctx_ff.hexa) begin
               a_ctx.acc = {ctx_ff.acc[27:0], hex_nib};
            end
         end
         ST_FMT: begin
            if (ch == CH_NL) begin
               a_save = 1'b0;
               a_tick = 1'b1;
            end else if (is_space(ch)) begin
               a_save = 1'b0;
            end else if ((ch == CH_ZERO) || (ch == CH_ONE)) begin
               a_save = 1'b1;
            end else if (ch == CH_LPAREN) begin
               a_ctx.st = ST_SUB;
            end else if (ch == CH_RBRACE) begin
               a_ctx.pend = TT_FORMAT;
               a_save     = 1'b0;
               a_done     = 1'b1;
            end else begin
               a_done = 1'b1;
            end
         end
         ST_SUB: begin
            if (ch == CH_NL) begin
               a_save = 1'b0;
               a_tick = 1'b1;
            end else if (is_space(ch)) begin
               a_save = 1'b0;
            end else if (is_digit(ch)) begin
               a_save = 1'b1;
            end else if (ch == CH_RPAREN) begin
               a_ctx.st = ST_FMT;
            end else begin
               a_done = 1'b1;
            end
         end
         default: begin
            a_ctx.pend = TT_ERROR;
            a_done     = 1'b1;
         end
      endcase
   end

   // start-state passes: direct, and the restart after a closing character
   always_comb begin
      kept_inc = {1'b0, a_ctx.kept} + (KW+1)'(1);
      back_ctx = a_done ? CTX_CLEAR : a_ctx;
      s_start  = start_feed(ch, ctx_ff, line_ff, line_inc);
      s_again  = start_feed(ch, back_ctx, line_ff, line_inc);
      a_end    = end_res(a_ctx.pend, a_ctx.acc, line_ff,
                         a_save ? kept_inc[KW-1:0] : a_ctx.kept);
   end

   // assemble the result bundle and the next context
   always_comb begin
      nxt_ctx = ctx_ff;
      nres    = 2'd0;
      r0      = '0;
      r1      = '0;
      r2      = '0;
      tick    = 1'b0;
      if (req_end_of_input) begin
         nres    = 2'd1;
         r0      = end_res(ctx_ff.pend, ctx_ff.acc, line_ff, ctx_ff.kept);
         nxt_ctx = CTX_CLEAR;
      end else if (ctx_ff.st == ST_START) begin
         nres    = s_start.n;
         r0      = s_start.r0;
         r1      = s_start.r1;
         nxt_ctx = s_start.ctx;
         tick    = s_start.tick;
      end else if (a_save) begin
         r0           = char_res(ch);
         nxt_ctx      = a_ctx;
         nxt_ctx.kept = kept_inc[KW-1:0];
         if (a_done || (kept_inc >= KEPT_LIMIT)) begin
            nres    = 2'd2;
            r1      = a_end;
            nxt_ctx = CTX_CLEAR;
         end else begin
            nres = 2'd1;
         end
      end else if (a_again) begin
         nxt_ctx = s_again.ctx;
         tick    = s_again.tick;
         if (a_done) begin
            nres = s_again.n + 2'd1;
            r0   = a_end;
            r1   = s_again.r0;
            r2   = s_again.r1;
         end else begin
            nres = s_again.n;
            r0   = s_again.r0;
            r1   = s_again.r1;
         end
      end else begin
         tick = a_tick;
         if (a_done) begin
            nres    = 2'd1;
            r0      = a_end;
            nxt_ctx = CTX_CLEAR;
         end else begin
            nxt_ctx = a_ctx;
         end
      end
   end

   // next register values
   always_comb begin
      ctx_in  = accept ? nxt_ctx : ctx_ff;
      line_in = line_ff;
      if (csr_wr_en) begin
         line_in = csr_wr_data;
      end else if (accept && tick) begin
         line_in = line_inc;
      end
   end

   assign push                = accept && (nres != 2'd0);
   assign push_bundle.count   = nres;
   assign push_bundle.slot[0] = r0;
   assign push_bundle.slot[1] = r1;
   assign push_bundle.slot[2] = r2;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctx_ff  <= CTX_CLEAR;
         line_ff <= LINE_RESET;
      end else begin
         ctx_ff  <= ctx_in;
         line_ff <= line_in;
      end
   end

`ifndef NO_ASSERTIONS
   // a token always closes before the buffer fills
   kept_below_limit_a: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, ctx_ff.kept} < KEPT_LIMIT))
      else $error("kept count reached token capacity");

   // the start state always holds a clean token context
   start_is_clean_a: assert property (@(posedge clock) disable iff (reset)
      (ctx_ff.st == ST_START) |-> ((ctx_ff.kept == '0) && (ctx_ff.acc == '0)
                                   && !ctx_ff.hexa && (ctx_ff.pend == TT_EOF)))
      else $error("start state entered with stale token context");
`endif

endmodule

/* hw/rtl/ats_queue.sv */
// ----------------------------------------------------------------------------
// ats_queue: bundle queue between lexer front and result back end
// Small register FIFO; full is decoded from the registered fill count so the
// front never waits on the output side combinationally.
// ----------------------------------------------------------------------------
module ats_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  ats_pkg::bundle_type  push_bundle,
   output logic                 full,
   input  logic                 pop,
   output logic                 valid,
   output ats_pkg::bundle_type  head
);
   import ats_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);

   bundle_type          store_ff [QUEUE_DEPTH];
   logic [PW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [PW:0]         count_ff, count_in;

   assign full  = (count_ff == (PW+1)'(QUEUE_DEPTH));
   assign valid = (count_ff != '0);
   assign head  = store_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in  = count_ff + (PW+1)'(push) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage write
   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_bundle;
      end
   end

`ifndef NO_ASSERTIONS
   no_overflow_a: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("bundle pushed into a full queue");

   no_underflow_a: assert property (@(posedge clock) disable iff (reset)
      !(pop && !valid))
      else $error("bundle popped from an empty queue");
`endif

endmodule

/* hw/rtl/ats_back.sv */
// ----------------------------------------------------------------------------
// ats_back: result back end
// Holds one bundle in an output register and sends its results one beat
// at a time, marking the final beat of each bundle.
// ----------------------------------------------------------------------------
module ats_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  ats_pkg::bundle_type  q_head,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_result_kind,
   output logic [7:0]           rsp_token_char,
   output logic [3:0]           rsp_token_type,
   output logic signed [31:0]   rsp_int_value,
   output logic [19:0]          rsp_line_number,
   output logic [7:0]           rsp_token_length,
   output logic                 rsp_last
);
   import ats_pkg::*;

   bundle_type    hold_ff, hold_in;
   logic          hold_valid_ff, hold_valid_in;
   logic [1:0]    idx_ff, idx_in;

   result_type    cur;
   logic          is_last;
   logic          out_beat;

   assign cur      = hold_ff.slot[idx_ff];
   assign is_last  = (idx_ff == (hold_ff.count - 2'd1));
   assign out_beat = hold_valid_ff && !rsp_stall;
   assign pop      = q_valid && (!hold_valid_ff || (out_beat && is_last));

   // step through the held bundle, reload when it is drained
   always_comb begin
      hold_in       = hold_ff;
      hold_valid_in = hold_valid_ff;
      idx_in        = idx_ff;
      if (pop) begin
         hold_in       = q_head;
         hold_valid_in = 1'b1;
         idx_in        = 2'd0;
      end else if (out_beat) begin
         if (is_last) begin
            hold_valid_in = 1'b0;
            idx_in        = 2'd0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         idx_ff        <= 2'd0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         idx_ff        <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
   end

   assign rsp_valid        = hold_valid_ff;
   assign rsp_result_kind  = cur.kind;
   assign rsp_token_char   = cur.ch;
   assign rsp_token_type   = cur.ttype;
   assign rsp_int_value    = $signed(cur.value);
   assign rsp_line_number  = cur.line;
   assign rsp_token_length = cur.len;
   assign rsp_last         = is_last;

`ifndef NO_ASSERTIONS
   index_in_bundle_a: assert property (@(posedge clock) disable iff (reset)
      hold_valid_ff |-> (idx_ff < hold_ff.count))
      else $error("result index past end of held bundle");
`endif

endmodule
